// ===== rtl/video_pixel_format_to_rgba_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel format converter
// Shared property forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PIXEL_FORMAT_TO_RGBA_UNIT_ASSERT_SVH
`define VIDEO_PIXEL_FORMAT_TO_RGBA_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VPF_AST_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpf assertion failed");

// Next-cycle implication, disabled in reset.
`define VPF_AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpf assertion failed");

// Next-cycle implication that is checked during reset as well.
`define VPF_AST_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vpf reset assertion failed");

`endif

// ===== rtl/vpf_pkg.sv =====
// ----------------------------------------------------------------------------
// vpf_pkg
// Types and constants shared by the pixel format converter.
// ----------------------------------------------------------------------------
package vpf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned SUM_W  = 20;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    FMT_BGRA = 3'd0,
    FMT_BGRX = 3'd1,
    FMT_RGBA = 3'd2,
    FMT_UYVY = 3'd3,
    FMT_NV12 = 3'd4
  } fmt_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [BYTE_W-1:0] luma;
    logic [BYTE_W-1:0] cb;
    logic [BYTE_W-1:0] cr;
  } ycc_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              last_pixel;
  } pixel_t;

endpackage

// ===== rtl/vpf_in_if.sv =====
// ----------------------------------------------------------------------------
// vpf_in_if
// Request channel carrying one four-byte source word.
// ----------------------------------------------------------------------------
interface vpf_in_if
  import vpf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_zero;
  logic [BYTE_W-1:0] byte_one;
  logic [BYTE_W-1:0] byte_two;
  logic [BYTE_W-1:0] byte_three;

  modport source (output valid, output byte_zero, output byte_one,
                  output byte_two, output byte_three, input ready);
  modport sink   (input valid, input byte_zero, input byte_one,
                  input byte_two, input byte_three, output ready);
endinterface

// ===== rtl/vpf_out_if.sv =====
// ----------------------------------------------------------------------------
// vpf_out_if
// Result channel carrying one RGBA pixel.
// ----------------------------------------------------------------------------
interface vpf_out_if
  import vpf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic              last_pixel;

  modport source (output valid, output red, output green, output blue,
                  output alpha, output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, input last_pixel, output ready);
endinterface

// ===== rtl/vpf_yuv_conv.sv =====
// ----------------------------------------------------------------------------
// vpf_yuv_conv
// Limited-range BT.601 YCbCr to RGB, combinational, constant coefficients.
// ----------------------------------------------------------------------------
module vpf_yuv_conv
  import vpf_pkg::*;
(
  input  ycc_t ycc,
  output rgb_t rgb
);

  // Clamp (sum >> 8) into 0..255; the shift is a floor.
  function automatic logic [BYTE_W-1:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:2*BYTE_W]) begin
      res = ALPHA_OPAQUE;
    end else begin
      res = sum[2*BYTE_W-1:BYTE_W];
    end
    return res;
  endfunction

  logic [BYTE_W-1:0]        y_off;
  logic signed [SUM_W-1:0]  y_s;
  logic signed [SUM_W-1:0]  u_s;
  logic signed [SUM_W-1:0]  v_s;
  logic signed [SUM_W-1:0]  c_s;
  logic signed [SUM_W-1:0]  r_sum;
  logic signed [SUM_W-1:0]  g_sum;
  logic signed [SUM_W-1:0]  b_sum;

  always_comb begin
    y_off = (ycc.luma < 8'd16) ? '0 : (ycc.luma - 8'd16);
    y_s   = $signed({{(SUM_W-BYTE_W){1'b0}}, y_off});
    // chroma - 128 is the byte with its top bit inverted, sign extended
    u_s   = $signed({{(SUM_W-BYTE_W+1){~ycc.cb[BYTE_W-1]}}, ycc.cb[BYTE_W-2:0]});
    v_s   = $signed({{(SUM_W-BYTE_W+1){~ycc.cr[BYTE_W-1]}}, ycc.cr[BYTE_W-2:0]});
    c_s   = y_s * 20'sd298;
    r_sum = c_s + v_s * 20'sd409 + 20'sd128;
    g_sum = c_s - u_s * 20'sd100 - v_s * 20'sd208 + 20'sd128;
    b_sum = c_s + u_s * 20'sd516 + 20'sd128;
    rgb.red   = clamp_shift(r_sum);
    rgb.green = clamp_shift(g_sum);
    rgb.blue  = clamp_shift(b_sum);
  end

endmodule

// ===== rtl/video_pixel_format_to_rgba_unit.sv =====
// Path: a request is accepted into the input register, then its pixel is loaded
// into the result register, which drives the result port.
// Throughput: one request per cycle while the result port accepts; UYVY requests
// give two pixels through the single result register. Undefined modes consume a
// request and emit nothing.
// Reset (rst_n, synchronous): both stages empty, mode_r = BGRA.
// ----------------------------------------------------------------------------
// video_pixel_format_to_rgba_unit
// Source word to RGBA converter: input register, conversion, result register.
// ----------------------------------------------------------------------------
module video_pixel_format_to_rgba_unit
  import vpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  vpf_in_if.sink            in_ch,
  vpf_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [MODE_W-1:0] cfg_wr_data
);

  logic [MODE_W-1:0] mode_r;

  logic              a_valid_r, a_valid_nxt;
  logic              a_phase_r, a_phase_nxt;
  logic [BYTE_W-1:0] a_b0_r, a_b1_r, a_b2_r, a_b3_r;

  logic              b_valid_r, b_valid_nxt;
  pixel_t            b_pix_r, pix_nxt;

  logic              in_acc;
  logic              is_drop;
  logic              a_final;
  logic              b_load;
  logic              a_free;

  ycc_t              ycc;
  rgb_t              rgb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= FMT_BGRA;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_comb begin
    is_drop = (mode_r > FMT_NV12);
    a_final = (mode_r != FMT_UYVY) || a_phase_r;
    b_load  = a_valid_r && !is_drop && (!b_valid_r || out_ch.ready);
    a_free  = a_valid_r && (is_drop || (b_load && a_final));
    in_acc  = in_ch.valid && in_ch.ready;
  end

  assign in_ch.ready = !a_valid_r || a_free;

  // Input stage: UYVY requests stay for a second pass (phase 1).
  always_comb begin
    a_valid_nxt = a_valid_r;
    a_phase_nxt = a_phase_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
      a_phase_nxt = 1'b0;
    end else if (a_free) begin
      a_valid_nxt = 1'b0;
    end else if (b_load) begin
      a_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_phase_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      a_phase_r <= a_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_b0_r <= in_ch.byte_zero;
      a_b1_r <= in_ch.byte_one;
      a_b2_r <= in_ch.byte_two;
      a_b3_r <= in_ch.byte_three;
    end
  end

  always_comb begin
    if (mode_r == FMT_NV12) begin
      ycc.luma = a_b0_r;
      ycc.cb   = a_b1_r;
    end else begin
      ycc.luma = a_phase_r ? a_b3_r : a_b1_r;
      ycc.cb   = a_b0_r;
    end
    ycc.cr = a_b2_r;
  end

  vpf_yuv_conv u_yuv (
    .ycc (ycc),
    .rgb (rgb)
  );

  always_comb begin
    pix_nxt.last_pixel = a_final;
    unique case (fmt_mode_t'(mode_r))
      FMT_BGRA: begin
        pix_nxt.red   = a_b2_r;
        pix_nxt.green = a_b1_r;
        pix_nxt.blue  = a_b0_r;
        pix_nxt.alpha = a_b3_r;
      end
      FMT_BGRX: begin
        pix_nxt.red   = a_b2_r;
        pix_nxt.green = a_b1_r;
        pix_nxt.blue  = a_b0_r;
        pix_nxt.alpha = ALPHA_OPAQUE;
      end
      FMT_RGBA: begin
        pix_nxt.red   = a_b0_r;
        pix_nxt.green = a_b1_r;
        pix_nxt.blue  = a_b2_r;
        pix_nxt.alpha = a_b3_r;
      end
      FMT_UYVY, FMT_NV12: begin
        pix_nxt.red   = rgb.red;
        pix_nxt.green = rgb.green;
        pix_nxt.blue  = rgb.blue;
        pix_nxt.alpha = ALPHA_OPAQUE;
      end
      default: begin
        pix_nxt.red   = '0;
        pix_nxt.green = '0;
        pix_nxt.blue  = '0;
        pix_nxt.alpha = '0;
      end
    endcase
  end

  // Result register
  always_comb begin
    b_valid_nxt = b_valid_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_pix_r <= pix_nxt;
    end
  end

  assign out_ch.valid      = b_valid_r;
  assign out_ch.red        = b_pix_r.red;
  assign out_ch.green      = b_pix_r.green;
  assign out_ch.blue       = b_pix_r.blue;
  assign out_ch.alpha      = b_pix_r.alpha;
  assign out_ch.last_pixel = b_pix_r.last_pixel;

endmodule

// ===== rtl/vpf_checker.sv =====
// ----------------------------------------------------------------------------
// vpf_checker
// Port-level checks for the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_pixel_format_to_rgba_unit_assert.svh"

module vpf_checker
  import vpf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_red,
  input logic [BYTE_W-1:0] out_alpha,
  input logic              out_last_pixel
);

  // Both stages are cleared by reset.
  `VPF_AST_RST(a_rst_empty, clk, !rst_n, !out_valid && in_ready)

  // First UYVY pixel is followed directly by its partner.
  `VPF_AST_NEXT(a_pair_follows, clk, rst_n,
    out_valid && out_ready && !out_last_pixel, out_valid && out_last_pixel)

  // A pixel that is not the last of its request is a YUV pixel: opaque.
  `VPF_AST_SAME(a_pair_opaque, clk, rst_n,
    out_valid && !out_last_pixel, out_alpha == ALPHA_OPAQUE)

  // Stalled result holds.
  `VPF_AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_red) && $stable(out_last_pixel))

endmodule

bind video_pixel_format_to_rgba_unit vpf_checker u_vpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_red        (out_ch.red),
  .out_alpha      (out_ch.alpha),
  .out_last_pixel (out_ch.last_pixel)
);
